// ===== hw/rtl/ts_packetizer_top_assert.svh =====
// Assertion macros for the packetizer RTL, included by tsp_back; they expect signals named clock and reset.
`ifndef TS_PACKETIZER_TOP_ASSERT_SVH
`define TS_PACKETIZER_TOP_ASSERT_SVH

// A property checked at every rising clock edge outside reset.
`define TSP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must never hold outside reset.
`define TSP_ASSERT_NEVER(lbl, cond, msg) \
   `TSP_ASSERT(lbl, !(cond), msg)

`endif

// ===== hw/rtl/tsp_pkg.sv =====
// Shared types and constants of the transport stream packetizer.
`timescale 1ns / 1ps
package tsp_pkg;

   localparam int BYTE_W          = 8;
   localparam int PID_W           = 13;
   localparam int CC_W            = 4;
   localparam int HEADER_BYTES    = 4;
   localparam int PACKET_SIZE_DEF = 188;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [BYTE_W-1:0] SYNC_BYTE    = 8'h47;
   localparam logic [3:0]        PAYLOAD_ONLY = 4'h1;
   localparam logic [PID_W-1:0]  PID_RESET    = 13'h1100;

   // One classified payload byte, with the header it needs if it opens a packet.
   typedef struct packed {
      logic              hdr;
      logic [BYTE_W-1:0] hdr_flags;
      logic [BYTE_W-1:0] hdr_pid;
      logic [BYTE_W-1:0] hdr_cc;
      logic [BYTE_W-1:0] data;
      logic              last;
   } tsp_entry_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic          valid;
      tsp_entry_type entry;
   } tsp_head_type;

endpackage

// ===== hw/rtl/ts_packetizer_top.sv =====
// Top level of the transport stream packetizer.
// Path: a payload byte that needs no header passes through a queue slot and then the output
// register; a byte that opens a packet follows its four header bytes, one per cycle.
// Throughput: one result byte per cycle while the consumer pops, set by the single output
// register; the input takes one byte per cycle until the queue fills while a header goes out.
// Reset: synchronous and active high; it empties the queue, restores identifier 0x1100.
`timescale 1ns / 1ps
module ts_packetizer_top #(
   parameter int PACKET_SIZE = tsp_pkg::PACKET_SIZE_DEF,  // 8 to 255
   parameter int QUEUE_DEPTH = tsp_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [tsp_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_stream_end,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [tsp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_packet_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [tsp_pkg::PID_W-1:0]  csr_data
);

   tsp_pkg::tsp_entry_type entry;
   tsp_pkg::tsp_head_type  head;
   logic                   accept;
   logic                   head_pop;
   logic                   out_valid;

   // The identifier register can always take a transfer; a new value reaches the next
   // header the front end builds.
   assign csr_ready = 1'b1;

   // A byte is taken whenever the queue has room, whatever the back end is doing.
   assign accept = req_push && !req_full;

   // The front end classifies each byte as it arrives: whether it opens a packet, whether
   // it closes one, and what the header of a new packet holds.
   tsp_front #(
      .PACKET_SIZE (PACKET_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .stream_end (req_stream_end),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .entry      (entry)
   );

   // The queue lets the front end keep accepting while the back end sends a header.
   tsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_entry (entry),
      .full       (req_full),
      .pop        (head_pop),
      .head       (head)
   );

   // The back end turns each entry into one or five result bytes, holding each in an
   // output register that refills in the same cycle as the consumer's transfer.
   tsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .out_valid (out_valid),
      .out_pop   (rsp_pop),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_packet_last)
   );

   assign rsp_empty = !out_valid;

endmodule

// ===== hw/rtl/tsp_front.sv =====
// Front end: holds the packet identifier, tracks packet position and builds header fields.
`timescale 1ns / 1ps
module tsp_front #(
   parameter int PACKET_SIZE = tsp_pkg::PACKET_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [tsp_pkg::BYTE_W-1:0] data_byte,
   input  logic                      stream_end,
   input  logic                      csr_write,
   input  logic [tsp_pkg::PID_W-1:0] csr_data,
   output tsp_pkg::tsp_entry_type    entry
);

   localparam int PAYLOAD = PACKET_SIZE - tsp_pkg::HEADER_BYTES;
   localparam int POS_W   = $clog2(PAYLOAD + 1);

   logic [tsp_pkg::PID_W-1:0] pid_ff, pid_in;
   logic [POS_W-1:0]          pos_ff, pos_in, pos_next;
   logic [tsp_pkg::CC_W-1:0]  cc_ff, cc_in;
   logic                      first_ff, first_in;
   logic                      opens;

   always_comb begin
      opens    = (pos_ff == '0);
      pos_next = pos_ff + 1'b1;

      entry.hdr       = opens;
      entry.hdr_flags = {1'b0, first_ff, 1'b0, pid_ff[12:8]};
      entry.hdr_pid   = pid_ff[7:0];
      entry.hdr_cc    = {tsp_pkg::PAYLOAD_ONLY, cc_ff};
      entry.data      = data_byte;
      entry.last      = stream_end || (pos_next == POS_W'(PAYLOAD));

      pid_in   = csr_write ? csr_data : pid_ff;
      pos_in   = pos_ff;
      cc_in    = cc_ff;
      first_in = first_ff;
      if (accept) begin
         pos_in = entry.last ? '0 : pos_next;
         if (opens) begin
            cc_in    = cc_ff + 1'b1;
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff   <= tsp_pkg::PID_RESET;
         pos_ff   <= '0;
         cc_ff    <= '0;
         first_ff <= 1'b1;
      end else begin
         pid_ff   <= pid_in;
         pos_ff   <= pos_in;
         cc_ff    <= cc_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== hw/rtl/tsp_queue.sv =====
// Short register queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module tsp_queue #(
   parameter int DEPTH = tsp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tsp_pkg::tsp_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output tsp_pkg::tsp_head_type  head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsp_pkg::tsp_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   always_comb begin
      full       = (cnt_ff == CNT_W'(DEPTH));
      head.valid = (cnt_ff != '0);
      head.entry = slot_ff[rd_ff];
      do_push    = push && !full;
      do_pop     = pop && head.valid;

      wr_in = wr_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      rd_in = rd_ff;
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/tsp_back.sv =====
// Back end: expands queued entries into header and payload bytes in an output register.
`timescale 1ns / 1ps
`include "ts_packetizer_top_assert.svh"
module tsp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tsp_pkg::tsp_head_type      head,
   output logic                       head_pop,
   output logic                       out_valid,
   input  logic                       out_pop,
   output logic [tsp_pkg::BYTE_W-1:0] out_byte,
   output logic                       out_last
);

   localparam logic [2:0] PH_SYNC  = 3'd0;
   localparam logic [2:0] PH_FLAGS = 3'd1;
   localparam logic [2:0] PH_PID   = 3'd2;
   localparam logic [2:0] PH_CC    = 3'd3;
   localparam logic [2:0] PH_DATA  = 3'd4;

   logic [2:0]                phase_ff, phase_in;
   logic                      valid_ff, valid_in;
   logic [tsp_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                      last_ff, last_in;
   logic                      load, emit_data;

   always_comb begin
      load      = head.valid && (!valid_ff || out_pop);
      emit_data = !head.entry.hdr || (phase_ff == PH_DATA);
      head_pop  = load && emit_data;

      unique case (phase_ff)
         PH_SYNC:  byte_in = tsp_pkg::SYNC_BYTE;
         PH_FLAGS: byte_in = head.entry.hdr_flags;
         PH_PID:   byte_in = head.entry.hdr_pid;
         PH_CC:    byte_in = head.entry.hdr_cc;
         default:  byte_in = head.entry.data;
      endcase
      if (emit_data) begin
         byte_in = head.entry.data;
      end
      last_in = emit_data && head.entry.last;

      valid_in = valid_ff;
      phase_in = phase_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = emit_data ? PH_SYNC : phase_ff + 1'b1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_SYNC;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   `TSP_ASSERT_NEVER(a_phase_range, phase_ff > PH_DATA, "header phase out of range")
   `TSP_ASSERT(a_head_held, (phase_ff != PH_SYNC) |-> head.valid, "entry left mid-header")
   `TSP_ASSERT(a_hdr_not_last, (load && !emit_data) |=> !last_ff, "last flag on a header byte")

endmodule
